FILE: rtl/pj_pkg.sv
// Shared types, constants and helpers for the pose projection Jacobian unit.
// No dependencies; every other file in rtl/ imports this package.
package pj_pkg;

	localparam int W = 32;
	localparam int NPREP = 28;
	localparam int NROWOP = 6;
	localparam int NROW = 7;
	localparam int NSLOT = NPREP + NROWOP;
	localparam int SLOTW = $clog2(NSLOT);
	localparam int NSRC = 22;
	localparam int QDEPTH = 2;
	localparam int QPW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);
	localparam int DIV_STEPS = 24;
	localparam int DIV_CW = $clog2(DIV_STEPS + 1);

	localparam logic signed [W-1:0] ONE_Q = 32'sd65536;
	localparam logic signed [W-1:0] DEPTH_A = -32'sd65667;
	localparam logic signed [W-1:0] DEPTH_B = -32'sd13120;

	localparam logic [2:0] LAST_ROW = 3'(NROW - 1);
	localparam logic [2:0] LAST_OP = 3'(NROWOP - 1);
	localparam logic [SLOTW-1:0] SLOT_DEPTH = SLOTW'(4);
	localparam logic [SLOTW-1:0] SLOT_R5 = SLOTW'(NSLOT - 1);

	localparam logic [2:0] CFG_FOCAL_X = 3'd0;
	localparam logic [2:0] CFG_FOCAL_Y = 3'd1;
	localparam logic [2:0] CFG_CENTER_X = 3'd2;
	localparam logic [2:0] CFG_CENTER_Y = 3'd3;
	localparam logic [2:0] CFG_QUAT_X = 3'd4;
	localparam logic [2:0] CFG_QUAT_Y = 3'd5;
	localparam logic [2:0] CFG_QUAT_Z = 3'd6;
	localparam logic [2:0] CFG_QUAT_W = 3'd7;

	typedef enum logic [4:0] {
		SRC_QX, SRC_QY, SRC_QZ, SRC_QW,
		SRC_OX, SRC_OY, SRC_OZ,
		SRC_CAMX, SRC_CAMY, SRC_CAMZ,
		SRC_FX, SRC_FY, SRC_CX, SRC_CY,
		SRC_DEPA, SRC_SUMX, SRC_SUMY, SRC_PX, SRC_PY,
		SRC_DX, SRC_DY, SRC_DZ
	} src_t;

	typedef struct packed {
		src_t a;
		src_t b;
	} opsel_t;

	// Product k of the per-point schedule lands in slot k.
	localparam opsel_t PREP_OPS [NPREP] = '{
		'{SRC_CX, SRC_CAMZ}, '{SRC_FX, SRC_CAMX}, '{SRC_CY, SRC_CAMZ}, '{SRC_FY, SRC_CAMY},
		'{SRC_DEPA, SRC_CAMZ},
		'{SRC_QX, SRC_QX}, '{SRC_QY, SRC_QY}, '{SRC_QZ, SRC_QZ}, '{SRC_QX, SRC_QY},
		'{SRC_QX, SRC_QZ}, '{SRC_QY, SRC_QZ}, '{SRC_QW, SRC_QX}, '{SRC_QW, SRC_QY},
		'{SRC_QW, SRC_QZ},
		'{SRC_QX, SRC_OX}, '{SRC_QX, SRC_OY}, '{SRC_QX, SRC_OZ},
		'{SRC_QY, SRC_OX}, '{SRC_QY, SRC_OY}, '{SRC_QY, SRC_OZ},
		'{SRC_QZ, SRC_OX}, '{SRC_QZ, SRC_OY}, '{SRC_QZ, SRC_OZ},
		'{SRC_QW, SRC_OX}, '{SRC_QW, SRC_OY}, '{SRC_QW, SRC_OZ},
		'{SRC_DEPA, SRC_SUMX}, '{SRC_DEPA, SRC_SUMY}
	};

	localparam opsel_t ROW_OPS [NROWOP] = '{
		'{SRC_CX, SRC_DZ}, '{SRC_FX, SRC_DX}, '{SRC_CY, SRC_DZ},
		'{SRC_FY, SRC_DY}, '{SRC_PX, SRC_DZ}, '{SRC_PY, SRC_DZ}
	};

	typedef struct packed {
		logic signed [W-1:0] fx;
		logic signed [W-1:0] fy;
		logic signed [W-1:0] cx;
		logic signed [W-1:0] cy;
		logic signed [W-1:0] qx;
		logic signed [W-1:0] qy;
		logic signed [W-1:0] qz;
		logic signed [W-1:0] qw;
	} cfg_t;

	typedef struct packed {
		logic signed [W-1:0] nx;
		logic signed [W-1:0] ny;
		logic signed [W-1:0] tx;
		logic signed [W-1:0] ty;
		logic signed [W-1:0] quo;
		logic err;
		logic [2:0] row;
		logic last;
	} row_entry_t;

	function automatic logic signed [W-1:0] sat32(input logic signed [47:0] v);
		if (v > 48'sh0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -48'sh0000_8000_0000)
			return 32'sh8000_0000;
		else
			return v[W-1:0];
	endfunction

	// Round to nearest (ties up) on the drop of 16 fraction bits, then saturate.
	function automatic logic signed [W-1:0] round_q16(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sd32768;
		return sat32(t[63:16]);
	endfunction

endpackage

FILE: rtl/pose_projection_jacobian_unit.sv
// Top level of the pose projection Jacobian unit: configuration registers,
// product front, row queue and divide back. Depends on pj_pkg, pj_front, pj_queue, pj_back.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | world_x..z, cam_x..z, centre_x..z
//   out     | output    | out_valid/out_stall| row_index, deriv_image_x/y, divide_error, last_row
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A point's products all go through one shared 32x32 multiplier in the front.
// Each row then takes three chained divides per lane in the back, plus a pop and an
// output load; with no output stall the divider sets the rate.
// A point with a zero divisor skips the divides, so the front sets the rate.
// Reset clears all control state; configuration returns to its reset values.
// A stalled output holds the back; a full row queue freezes the front.
module pose_projection_jacobian_unit
	import pj_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [W-1:0]        cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [W-1:0] world_x,
	input  logic signed [W-1:0] world_y,
	input  logic signed [W-1:0] world_z,
	input  logic signed [W-1:0] cam_x,
	input  logic signed [W-1:0] cam_y,
	input  logic signed [W-1:0] cam_z,
	input  logic signed [W-1:0] centre_x,
	input  logic signed [W-1:0] centre_y,
	input  logic signed [W-1:0] centre_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          row_index,
	output logic signed [W-1:0] deriv_image_x,
	output logic signed [W-1:0] deriv_image_y,
	output logic                divide_error,
	output logic                last_row
);

	cfg_t       cfg_q;
	logic       push;
	logic       full;
	row_entry_t push_data;
	logic       pop_valid;
	logic       pop;
	row_entry_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fx <= ONE_Q;
			cfg_q.fy <= ONE_Q;
			cfg_q.cx <= '0;
			cfg_q.cy <= '0;
			cfg_q.qx <= '0;
			cfg_q.qy <= '0;
			cfg_q.qz <= '0;
			cfg_q.qw <= ONE_Q;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FOCAL_X:  cfg_q.fx <= cfg_data;
				CFG_FOCAL_Y:  cfg_q.fy <= cfg_data;
				CFG_CENTER_X: cfg_q.cx <= cfg_data;
				CFG_CENTER_Y: cfg_q.cy <= cfg_data;
				CFG_QUAT_X:   cfg_q.qx <= cfg_data;
				CFG_QUAT_Y:   cfg_q.qy <= cfg_data;
				CFG_QUAT_Z:   cfg_q.qz <= cfg_data;
				CFG_QUAT_W:   cfg_q.qw <= cfg_data;
				default: ;
			endcase
		end
	end

	pj_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.world_x  (world_x),
		.world_y  (world_y),
		.world_z  (world_z),
		.cam_x    (cam_x),
		.cam_y    (cam_y),
		.cam_z    (cam_z),
		.centre_x (centre_x),
		.centre_y (centre_y),
		.centre_z (centre_z),
		.push     (push),
		.push_full(full),
		.push_data(push_data)
	);

	pj_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop_valid(pop_valid),
		.pop      (pop),
		.pop_data (pop_data)
	);

	pj_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop          (pop),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.row_index    (row_index),
		.deriv_image_x(deriv_image_x),
		.deriv_image_y(deriv_image_y),
		.divide_error (divide_error),
		.last_row     (last_row)
	);

endmodule

FILE: rtl/pj_div.sv
// Iterative Q16.16 divider, two quotient bits per cycle, round to nearest.
// Depends on pj_pkg.
module pj_div
	import pj_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic                done,
	output logic signed [W-1:0] quo
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              neg_q;
	logic [W-1:0]      den_q;
	logic [W-1:0]      rem_q;
	logic [47:0]       dvd_q;
	logic [47:0]       quot_q;

	logic [W-1:0] abs_n;
	logic [W-1:0] abs_d;
	logic [W:0]   t1;
	logic [W:0]   t2;
	logic         b1;
	logic         b2;
	logic [W-1:0] r1;
	logic [W-1:0] r2;

	assign abs_n = num[W-1] ? W'(-num) : W'(num);
	assign abs_d = den[W-1] ? W'(-den) : W'(den);

	always_comb begin
		t1 = {rem_q, dvd_q[47]};
		b1 = t1 >= {1'b0, den_q};
		r1 = b1 ? W'(t1 - {1'b0, den_q}) : t1[W-1:0];
		t2 = {r1, dvd_q[46]};
		b2 = t2 >= {1'b0, den_q};
		r2 = b2 ? W'(t2 - {1'b0, den_q}) : t2[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= num[W-1] ^ den[W-1];
			den_q  <= abs_d;
			rem_q  <= '0;
			dvd_q  <= {abs_n, 16'b0} + 48'(abs_d >> 1);
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= r2;
			dvd_q  <= {dvd_q[45:0], 2'b00};
			quot_q <= {quot_q[45:0], b1, b2};
		end
	end

	assign done = done_q;

	always_comb begin
		if (neg_q)
			quo = (|quot_q[47:31]) ? 32'sh8000_0000 : W'(-quot_q[W-1:0]);
		else
			quo = (|quot_q[47:31]) ? 32'sh7FFF_FFFF : quot_q[W-1:0];
	end

endmodule

FILE: rtl/pj_queue.sv
// Two-entry queue of Jacobian row jobs between the product front and the divide back.
// Depends on pj_pkg.
module pj_queue
	import pj_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  row_entry_t push_data,
	output logic       full,
	output logic       pop_valid,
	input  logic       pop,
	output row_entry_t pop_data
);

	row_entry_t       mem_q [QDEPTH];
	logic [QPW-1:0]   wr_q;
	logic [QPW-1:0]   rd_q;
	logic [QCW-1:0]   cnt_q;

	assign full      = cnt_q == QCW'(QDEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

FILE: rtl/pj_front.sv
// Front end: input buffer, shared Q16.16 multiplier and product schedule per point.
// Pushes one row job per Jacobian row into pj_queue. Depends on pj_pkg.
module pj_front
	import pj_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [W-1:0] world_x,
	input  logic signed [W-1:0] world_y,
	input  logic signed [W-1:0] world_z,
	input  logic signed [W-1:0] cam_x,
	input  logic signed [W-1:0] cam_y,
	input  logic signed [W-1:0] cam_z,
	input  logic signed [W-1:0] centre_x,
	input  logic signed [W-1:0] centre_y,
	input  logic signed [W-1:0] centre_z,
	output logic                push,
	input  logic                push_full,
	output row_entry_t          push_data
);

	function automatic logic signed [36:0] e(input logic signed [W-1:0] v);
		return 37'(v);
	endfunction

	// Input buffer
	logic                buf_vld_q;
	logic signed [W-1:0] bwx_q, bwy_q, bwz_q;
	logic signed [W-1:0] bcx_q, bcy_q, bcz_q;
	logic signed [W-1:0] bpx_q, bpy_q, bpz_q;

	// Point being worked on
	logic signed [W-1:0] ox_q, oy_q, oz_q;
	logic signed [W-1:0] camx_q, camy_q, camz_q;

	logic       run_q;
	logic       prep_q;
	logic [4:0] step_q;
	logic [2:0] row_q;
	logic [2:0] op_q;

	logic                    vld_s1;
	logic [SLOTW-1:0]        dst_s1;
	logic signed [63:0]      prod_s1;
	logic [2:0]              row_s1;

	logic signed [W-1:0] slot_q [NSLOT];

	logic                start;
	logic                last_issue;
	logic                issue;
	logic                freeze;
	logic                push_cond;
	opsel_t              sel;
	logic signed [W-1:0] srcv [NSRC];
	logic signed [W-1:0] mq;
	logic signed [W-1:0] quo;
	logic signed [36:0]  sx, sy, sz;
	logic signed [W-1:0] dx, dy, dz;

	logic signed [W-1:0] qxx, qyy, qzz, qxy, qxz, qyz, qwx, qwy, qwz;
	logic signed [W-1:0] xox, xoy, xoz, yox, yoy, yoz, zox, zoy, zoz, wox, woy, woz;

	assign qxx = slot_q[5];
	assign qyy = slot_q[6];
	assign qzz = slot_q[7];
	assign qxy = slot_q[8];
	assign qxz = slot_q[9];
	assign qyz = slot_q[10];
	assign qwx = slot_q[11];
	assign qwy = slot_q[12];
	assign qwz = slot_q[13];
	assign xox = slot_q[14];
	assign xoy = slot_q[15];
	assign xoz = slot_q[16];
	assign yox = slot_q[17];
	assign yoy = slot_q[18];
	assign yoz = slot_q[19];
	assign zox = slot_q[20];
	assign zoy = slot_q[21];
	assign zoz = slot_q[22];
	assign wox = slot_q[23];
	assign woy = slot_q[24];
	assign woz = slot_q[25];

	// Partials of camera-frame position for the current row
	always_comb begin
		case (row_q)
			3'd0: begin
				sx = (e(qzz) <<< 1) + (e(qyy) <<< 1) - e(ONE_Q);
				sy = -(e(qwz) <<< 1) - (e(qxy) <<< 1);
				sz = (e(qwy) <<< 1) - (e(qxz) <<< 1);
			end
			3'd1: begin
				sx = (e(qwz) <<< 1) - (e(qxy) <<< 1);
				sy = (e(qzz) <<< 1) + (e(qxx) <<< 1) - e(ONE_Q);
				sz = -(e(qyz) <<< 1) - (e(qwx) <<< 1);
			end
			3'd2: begin
				sx = -(e(qxz) <<< 1) - (e(qwy) <<< 1);
				sy = (e(qwx) <<< 1) - (e(qyz) <<< 1);
				sz = (e(qyy) <<< 1) + (e(qxx) <<< 1) - e(ONE_Q);
			end
			3'd3: begin
				sx = (e(zoz) <<< 1) + (e(yoy) <<< 1);
				sy = -(e(woz) <<< 1) - (e(xoy) <<< 2) + (e(yox) <<< 1);
				sz = -(e(xoz) <<< 2) + (e(woy) <<< 1) + (e(zox) <<< 1);
			end
			3'd4: begin
				sx = (e(woz) <<< 1) + (e(xoy) <<< 1) - (e(yox) <<< 2);
				sy = (e(zoz) <<< 1) + (e(xox) <<< 1);
				sz = -(e(yoz) <<< 2) + (e(zoy) <<< 1) - (e(wox) <<< 1);
			end
			3'd5: begin
				sx = (e(xoz) <<< 1) - (e(woy) <<< 1) - (e(zox) <<< 2);
				sy = (e(yoz) <<< 1) - (e(zoy) <<< 2) + (e(wox) <<< 1);
				sz = (e(yoy) <<< 1) + (e(xox) <<< 1);
			end
			3'd6: begin
				sx = (e(yoz) <<< 1) - (e(zoy) <<< 1);
				sy = (e(zox) <<< 1) - (e(xoz) <<< 1);
				sz = (e(xoy) <<< 1) - (e(yox) <<< 1);
			end
			default: begin
				sx = '0;
				sy = '0;
				sz = '0;
			end
		endcase
		dx = sat32(48'(sx));
		dy = sat32(48'(sy));
		dz = sat32(48'(sz));
	end

	assign srcv[SRC_QX]   = cfg.qx;
	assign srcv[SRC_QY]   = cfg.qy;
	assign srcv[SRC_QZ]   = cfg.qz;
	assign srcv[SRC_QW]   = cfg.qw;
	assign srcv[SRC_OX]   = ox_q;
	assign srcv[SRC_OY]   = oy_q;
	assign srcv[SRC_OZ]   = oz_q;
	assign srcv[SRC_CAMX] = camx_q;
	assign srcv[SRC_CAMY] = camy_q;
	assign srcv[SRC_CAMZ] = camz_q;
	assign srcv[SRC_FX]   = cfg.fx;
	assign srcv[SRC_FY]   = cfg.fy;
	assign srcv[SRC_CX]   = cfg.cx;
	assign srcv[SRC_CY]   = cfg.cy;
	assign srcv[SRC_DEPA] = DEPTH_A;
	assign srcv[SRC_SUMX] = sat32(48'(e(slot_q[0]) + e(slot_q[1])));
	assign srcv[SRC_SUMY] = sat32(48'(e(slot_q[2]) + e(slot_q[3])));
	assign srcv[SRC_PX]   = slot_q[26];
	assign srcv[SRC_PY]   = slot_q[27];
	assign srcv[SRC_DX]   = dx;
	assign srcv[SRC_DY]   = dy;
	assign srcv[SRC_DZ]   = dz;

	assign sel = prep_q ? PREP_OPS[step_q] : ROW_OPS[op_q];

	assign mq        = round_q16(prod_s1);
	assign push_cond = vld_s1 && (dst_s1 == SLOT_R5);
	assign freeze    = push_cond && push_full;
	assign push      = push_cond && !push_full;

	assign last_issue = run_q && !prep_q && (row_q == LAST_ROW) && (op_q == LAST_OP);
	assign issue      = run_q && !freeze;
	assign start      = buf_vld_q && (!run_q || last_issue) && !freeze;
	assign in_stall   = buf_vld_q;

	assign quo = sat32(48'(e(slot_q[SLOT_DEPTH]) + e(DEPTH_B)));

	assign push_data.nx   = sat32(48'(e(slot_q[NPREP]) + e(slot_q[NPREP + 1])));
	assign push_data.ny   = sat32(48'(e(slot_q[NPREP + 2]) + e(slot_q[NPREP + 3])));
	assign push_data.tx   = slot_q[NPREP + 4];
	assign push_data.ty   = mq;
	assign push_data.quo  = quo;
	assign push_data.err  = quo == '0;
	assign push_data.row  = row_s1;
	assign push_data.last = row_s1 == LAST_ROW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_vld_q <= 1'b0;
			run_q     <= 1'b0;
			prep_q    <= 1'b0;
			step_q    <= '0;
			row_q     <= '0;
			op_q      <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				buf_vld_q <= 1'b1;
			else if (start)
				buf_vld_q <= 1'b0;

			if (!freeze)
				vld_s1 <= issue;

			// A new point takes over right at the last issue of the previous one.
			if (start) begin
				run_q  <= 1'b1;
				prep_q <= 1'b1;
				step_q <= '0;
			end else if (issue) begin
				if (prep_q) begin
					if (step_q == 5'(NPREP - 1)) begin
						prep_q <= 1'b0;
						row_q  <= '0;
						op_q   <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end else if (op_q == LAST_OP) begin
					op_q <= '0;
					if (row_q == LAST_ROW)
						run_q <= 1'b0;
					else
						row_q <= row_q + 1'b1;
				end else begin
					op_q <= op_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			bwx_q <= world_x;
			bwy_q <= world_y;
			bwz_q <= world_z;
			bcx_q <= cam_x;
			bcy_q <= cam_y;
			bcz_q <= cam_z;
			bpx_q <= centre_x;
			bpy_q <= centre_y;
			bpz_q <= centre_z;
		end
		if (start) begin
			ox_q   <= sat32(48'(e(bwx_q) - e(bpx_q)));
			oy_q   <= sat32(48'(e(bwy_q) - e(bpy_q)));
			oz_q   <= sat32(48'(e(bwz_q) - e(bpz_q)));
			camx_q <= bcx_q;
			camy_q <= bcy_q;
			camz_q <= bcz_q;
		end
		if (issue) begin
			prod_s1 <= 64'(srcv[sel.a]) * 64'(srcv[sel.b]);
			dst_s1  <= prep_q ? SLOTW'(step_q) : SLOTW'(NPREP) + SLOTW'(op_q);
			row_s1  <= row_q;
		end
		if (vld_s1 && !freeze)
			slot_q[dst_s1] <= mq;
	end

endmodule

FILE: rtl/pj_back.sv
// Back end: per row job, three chained divides on x and y lanes, saturated difference,
// and the output register; zero divisors skip the divides. Depends on pj_pkg, pj_div.
module pj_back
	import pj_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop,
	input  row_entry_t          pop_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          row_index,
	output logic signed [W-1:0] deriv_image_x,
	output logic signed [W-1:0] deriv_image_y,
	output logic                divide_error,
	output logic                last_row
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV1 = 3'd1;
	localparam logic [2:0] ST_DIV2 = 3'd2;
	localparam logic [2:0] ST_DIV3 = 3'd3;
	localparam logic [2:0] ST_HOLD = 3'd4;

	logic [2:0]          state_q;
	row_entry_t          ent_q;
	logic signed [W-1:0] d1x_q, d1y_q;
	logic signed [W-1:0] resx_q, resy_q;

	logic                out_vld_q;
	logic [2:0]          orow_q;
	logic signed [W-1:0] ox_q, oy_q;
	logic                oerr_q;
	logic                olast_q;

	logic                div_start;
	logic signed [W-1:0] div_nx, div_ny, div_d;
	logic                done_x, done_y;
	logic signed [W-1:0] qx, qy;
	logic                load_out;

	pj_div u_div_x (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_nx),
		.den   (div_d),
		.done  (done_x),
		.quo   (qx)
	);

	pj_div u_div_y (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_ny),
		.den   (div_d),
		.done  (done_y),
		.quo   (qy)
	);

	assign pop      = (state_q == ST_IDLE) && pop_valid;
	assign load_out = (state_q == ST_HOLD) && (!out_vld_q || !out_stall);

	always_comb begin
		div_start = 1'b0;
		div_nx    = pop_data.nx;
		div_ny    = pop_data.ny;
		div_d     = ent_q.quo;
		case (state_q)
			ST_IDLE: begin
				div_start = pop_valid && !pop_data.err;
				div_d     = pop_data.quo;
			end
			ST_DIV1: begin
				div_start = done_x;
				div_nx    = ent_q.tx;
				div_ny    = ent_q.ty;
			end
			ST_DIV2: begin
				div_start = done_x;
				div_nx    = qx;
				div_ny    = qy;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop_valid)
						state_q <= pop_data.err ? ST_HOLD : ST_DIV1;
				end
				ST_DIV1: begin
					if (done_x)
						state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (done_x)
						state_q <= ST_DIV3;
				end
				ST_DIV3: begin
					if (done_x && done_y)
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load_out)
				out_vld_q <= 1'b1;
			else if (!out_stall)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q  <= pop_data;
			resx_q <= '0;
			resy_q <= '0;
		end
		if (state_q == ST_DIV1 && done_x) begin
			d1x_q <= qx;
			d1y_q <= qy;
		end
		if (state_q == ST_DIV3 && done_x) begin
			resx_q <= sat32(48'(d1x_q) - 48'(qx));
			resy_q <= sat32(48'(d1y_q) - 48'(qy));
		end
		if (load_out) begin
			orow_q  <= ent_q.row;
			ox_q    <= resx_q;
			oy_q    <= resy_q;
			oerr_q  <= ent_q.err;
			olast_q <= ent_q.last;
		end
	end

	assign out_valid     = out_vld_q;
	assign row_index     = orow_q;
	assign deriv_image_x = ox_q;
	assign deriv_image_y = oy_q;
	assign divide_error  = oerr_q;
	assign last_row      = olast_q;

endmodule
